/* src/sensor_gimbal_pointing_unit_macros.svh */
// Assertion helpers for the gimbal pointing unit.
// Each macro expects clk and rst in scope.
`ifndef SENSOR_GIMBAL_POINTING_UNIT_MACROS_SVH
`define SENSOR_GIMBAL_POINTING_UNIT_MACROS_SVH

`define SGP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gimbal pointing check failed");

`define SGP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gimbal pointing check failed");

`define SGP_ASSERT_AFTER_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("gimbal pointing check failed after reset");

`endif

/* src/sgp_pkg.sv */
package sgp_pkg;

  localparam int NORM_BITS     = 28;
  localparam int ROOT_BITS     = NORM_BITS + 1;
  localparam int RAD_BITS      = 2 * ROOT_BITS;
  localparam int REM_BITS      = ROOT_BITS + 1;
  localparam int TAN_BITS      = 35;
  localparam int PROD_BITS     = 64;
  localparam int DEG_BITS      = 6;
  localparam int SQRT_STAGES   = ROOT_BITS;
  localparam int SEARCH_STAGES = DEG_BITS;
  localparam int NSTAGE        = 8 + SQRT_STAGES + 1 + SEARCH_STAGES + 4;

  localparam logic [33:0] TAN_ONE    = 34'd10000000000;
  localparam logic [18:0] DIV_OFFSET = 19'd184320;
  localparam logic [19:0] DIV_MUL    = 20'd745655;
  localparam int          DIV_SHIFT  = 25;

  localparam logic [7:0]  RST_STEP_TIME  = 8'd51;
  localparam logic [9:0]  RST_REF_HEIGHT = 10'd150;
  localparam logic [11:0] RST_PAN_MIN    = 12'd715;
  localparam logic [11:0] RST_PAN_MAX    = 12'd2345;
  localparam logic [11:0] RST_TILT_MIN   = 12'd590;
  localparam logic [11:0] RST_TILT_MAX   = 12'd2360;

  typedef enum logic [2:0] {
    REG_STEP_TIME  = 3'd0,
    REG_REF_HEIGHT = 3'd1,
    REG_PAN_MIN    = 3'd2,
    REG_PAN_MAX    = 3'd3,
    REG_TILT_MIN   = 3'd4,
    REG_TILT_MAX   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [NORM_BITS-1:0] pan_p;
    logic [NORM_BITS-1:0] pan_q;
    logic [NORM_BITS-1:0] tilt_y;
    logic                 pan_neg;
    logic                 tilt_neg;
  } side_t;

  typedef struct packed {
    logic [RAD_BITS-1:0]  rad;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
    side_t                side;
  } sqrt_t;

  typedef struct packed {
    logic [ROOT_BITS-1:0] a;
    logic [PROD_BITS-1:0] b;
    logic [DEG_BITS-1:0]  d;
    logic                 zero_num;
    logic                 num_le;
    logic                 den_zero;
    logic                 neg;
  } atan_t;

  function automatic logic [TAN_BITS-1:0] tan_val(input logic [DEG_BITS-1:0] d);
    logic [TAN_BITS-1:0] t;
    case (d)
      6'd0:  t = 35'd0;
      6'd1:  t = 35'd174550649;
      6'd2:  t = 35'd349207695;
      6'd3:  t = 35'd524077793;
      6'd4:  t = 35'd699268119;
      6'd5:  t = 35'd874886635;
      6'd6:  t = 35'd1051042353;
      6'd7:  t = 35'd1227845609;
      6'd8:  t = 35'd1405408347;
      6'd9:  t = 35'd1583844403;
      6'd10: t = 35'd1763269807;
      6'd11: t = 35'd1943803091;
      6'd12: t = 35'd2125565617;
      6'd13: t = 35'd2308681911;
      6'd14: t = 35'd2493280028;
      6'd15: t = 35'd2679491924;
      6'd16: t = 35'd2867453858;
      6'd17: t = 35'd3057306815;
      6'd18: t = 35'd3249196962;
      6'd19: t = 35'd3443276133;
      6'd20: t = 35'd3639702343;
      6'd21: t = 35'd3838640350;
      6'd22: t = 35'd4040262258;
      6'd23: t = 35'd4244748162;
      6'd24: t = 35'd4452286853;
      6'd25: t = 35'd4663076582;
      6'd26: t = 35'd4877325886;
      6'd27: t = 35'd5095254495;
      6'd28: t = 35'd5317094317;
      6'd29: t = 35'd5543090515;
      6'd30: t = 35'd5773502692;
      6'd31: t = 35'd6008606190;
      6'd32: t = 35'd6248693519;
      6'd33: t = 35'd6494075932;
      6'd34: t = 35'd6745085168;
      6'd35: t = 35'd7002075382;
      6'd36: t = 35'd7265425280;
      6'd37: t = 35'd7535540501;
      6'd38: t = 35'd7812856265;
      6'd39: t = 35'd8097840332;
      6'd40: t = 35'd8390996312;
      6'd41: t = 35'd8692867378;
      6'd42: t = 35'd9004040443;
      6'd43: t = 35'd9325150861;
      6'd44: t = 35'd9656887748;
      6'd45: t = 35'd10000000000;
      default: t = '1;
    endcase
    return t;
  endfunction

  function automatic atan_t atan_prep(input logic [ROOT_BITS-1:0] p,
                                      input logic [ROOT_BITS-1:0] q,
                                      input logic neg);
    atan_t s;
    logic [ROOT_BITS-1:0] x;
    s.num_le   = (p <= q);
    s.zero_num = (p == '0);
    s.den_zero = (q == '0);
    s.neg      = neg;
    s.d        = '0;
    x          = s.num_le ? p : q;
    s.a        = s.num_le ? q : p;
    s.b        = PROD_BITS'(x) * PROD_BITS'(TAN_ONE)
                 - (s.num_le ? PROD_BITS'(0) : PROD_BITS'(1));
    return s;
  endfunction

  function automatic atan_t atan_step(input atan_t s, input logic [DEG_BITS-1:0] mask);
    atan_t n;
    logic [DEG_BITS-1:0]  cand;
    logic [PROD_BITS-1:0] prod;
    n    = s;
    cand = s.d | mask;
    prod = PROD_BITS'(tan_val(cand)) * PROD_BITS'(s.a);
    if (prod <= s.b) n.d = cand;
    return n;
  endfunction

  function automatic logic [7:0] atan_angle(input atan_t s);
    logic [7:0] mag;
    if (s.zero_num)      mag = 8'd0;
    else if (s.num_le)   mag = 8'(s.d);
    else if (s.den_zero) mag = 8'd89;
    else                 mag = 8'd89 - 8'(s.d);
    return s.neg ? 8'd90 - mag : 8'd90 + mag;
  endfunction

endpackage

/* src/sensor_gimbal_pointing_unit.sv */
// Throughput: one sample per cycle while the command side does not stall; the
// 29-stage square root of the tilt divisor and the 6-stage degree search set
// the pipeline depth.
// A stall at the command side freezes the whole pipeline; nothing is lost.
// Reset (synchronous, active high) clears all stage valid bits and loads the
// configuration registers with their default values.
`include "sensor_gimbal_pointing_unit_macros.svh"

module sensor_gimbal_pointing_unit #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic signed [15:0] roll_sin,
  input  logic signed [15:0] roll_cos,
  input  logic signed [15:0] pitch_sin,
  input  logic signed [15:0] pitch_cos,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output logic [7:0]         pan_angle,
  output logic [7:0]         tilt_angle,
  output logic [11:0]        pan_pulse,
  output logic [11:0]        tilt_pulse
);

  localparam int F   = TRIG_FRAC_BITS;
  localparam int SW  = ((57 > 41 + F) ? 57 : 41 + F) + 2;
  localparam int SHW = $clog2(SW) + 1;
  localparam int NS  = sgp_pkg::NSTAGE;

  function automatic logic [SHW-1:0] shift_for(input logic [SW-1:0] v);
    logic [SHW-1:0] n;
    n = '0;
    for (int i = 0; i < SW; i++) begin
      if (v[i]) n = SHW'(i + 1);
    end
    return (n > SHW'(sgp_pkg::NORM_BITS)) ? n - SHW'(sgp_pkg::NORM_BITS) : '0;
  endfunction

  logic [7:0]  step_time;
  logic [9:0]  ref_height;
  logic [11:0] pan_min, pan_max, tilt_min, tilt_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time  <= sgp_pkg::RST_STEP_TIME;
      ref_height <= sgp_pkg::RST_REF_HEIGHT;
      pan_min    <= sgp_pkg::RST_PAN_MIN;
      pan_max    <= sgp_pkg::RST_PAN_MAX;
      tilt_min   <= sgp_pkg::RST_TILT_MIN;
      tilt_max   <= sgp_pkg::RST_TILT_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        sgp_pkg::REG_STEP_TIME:  step_time  <= cfg_data[7:0];
        sgp_pkg::REG_REF_HEIGHT: ref_height <= cfg_data[9:0];
        sgp_pkg::REG_PAN_MIN:    pan_min    <= cfg_data;
        sgp_pkg::REG_PAN_MAX:    pan_max    <= cfg_data;
        sgp_pkg::REG_TILT_MIN:   tilt_min   <= cfg_data;
        sgp_pkg::REG_TILT_MAX:   tilt_max   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic          adv;
  logic [NS-1:0] vld;

  assign adv          = !vld[NS-1] || cmd_ready;
  assign sample_ready = adv;
  assign cmd_valid    = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], sample_valid};
    end
  end

  logic signed [18:0] h_s;
  logic signed [8:0]  dt_s;
  assign h_s  = $signed({1'b0, ref_height, 8'd0});
  assign dt_s = $signed({1'b0, step_time});

  // products of the inputs
  logic signed [24:0] vp, vq;
  logic signed [31:0] srsp, srcp, crsp, crcp;
  logic signed [34:0] sph;
  logic signed [15:0] cp1, cr1, sr1;

  always_ff @(posedge clk) begin
    if (adv) begin
      vp   <= 25'(vel_x * dt_s);
      vq   <= 25'(vel_y * dt_s);
      srsp <= roll_sin * pitch_sin;
      srcp <= roll_sin * pitch_cos;
      crsp <= roll_cos * pitch_sin;
      crcp <= roll_cos * pitch_cos;
      sph  <= 35'(pitch_sin * h_s);
      cp1  <= pitch_cos;
      cr1  <= roll_cos;
      sr1  <= roll_sin;
    end
  end

  logic signed [40:0] cpp, crq, srq;
  logic signed [56:0] srspp, crspp;
  logic signed [50:0] srcph, crcph;
  logic signed [34:0] sph2;

  always_ff @(posedge clk) begin
    if (adv) begin
      cpp   <= 41'(cp1 * vp);
      crq   <= 41'(cr1 * vq);
      srq   <= 41'(sr1 * vq);
      srspp <= 57'(srsp * vp);
      crspp <= 57'(crsp * vp);
      srcph <= 51'(srcp * h_s);
      crcph <= 51'(crcp * h_s);
      sph2  <= sph;
    end
  end

  // pointing vector
  logic signed [SW-1:0] sx, sy, sz, sx_next, sy_next, sz_next;

  always_comb begin
    sx_next = (SW'(cpp) - SW'(sph2)) <<< F;
    sy_next = SW'(srspp) + (SW'(crq) <<< F) + SW'(srcph);
    sz_next = SW'(crspp) - (SW'(srq) <<< F) + SW'(crcph);
    if (sz_next == '0) sz_next = SW'(1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx <= sx_next;
      sy <= sy_next;
      sz <= sz_next;
    end
  end

  logic [SW-1:0] ax, ay, az;
  logic          pan_neg4, tilt_neg4;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax        <= sx[SW-1] ? SW'(-sx) : SW'(sx);
      ay        <= sy[SW-1] ? SW'(-sy) : SW'(sy);
      az        <= sz[SW-1] ? SW'(-sz) : SW'(sz);
      pan_neg4  <= sx[SW-1] ^ sz[SW-1];
      tilt_neg4 <= sy[SW-1] ~^ sz[SW-1];
    end
  end

  logic [SW-1:0]  ax5, ay5, az5;
  logic [SHW-1:0] pan_sh, tilt_sh;
  logic           pan_neg5, tilt_neg5;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax5       <= ax;
      ay5       <= ay;
      az5       <= az;
      pan_sh    <= shift_for(ax | az);
      tilt_sh   <= shift_for(ax | ay | az);
      pan_neg5  <= pan_neg4;
      tilt_neg5 <= tilt_neg4;
    end
  end

  logic [sgp_pkg::NORM_BITS-1:0] tx6, tz6;
  sgp_pkg::side_t                side6, side7;

  always_ff @(posedge clk) begin
    if (adv) begin
      side6.pan_p    <= sgp_pkg::NORM_BITS'(ax5 >> pan_sh);
      side6.pan_q    <= sgp_pkg::NORM_BITS'(az5 >> pan_sh);
      side6.tilt_y   <= sgp_pkg::NORM_BITS'(ay5 >> tilt_sh);
      side6.pan_neg  <= pan_neg5;
      side6.tilt_neg <= tilt_neg5;
      tx6            <= sgp_pkg::NORM_BITS'(ax5 >> tilt_sh);
      tz6            <= sgp_pkg::NORM_BITS'(az5 >> tilt_sh);
    end
  end

  logic [2*sgp_pkg::NORM_BITS-1:0] xx, zz;

  always_ff @(posedge clk) begin
    if (adv) begin
      xx    <= tx6 * tx6;
      zz    <= tz6 * tz6;
      side7 <= side6;
    end
  end

  // square root, one result bit per stage
  sgp_pkg::sqrt_t sq [0:sgp_pkg::SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0].rad  <= sgp_pkg::RAD_BITS'(xx) + sgp_pkg::RAD_BITS'(zz);
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      sq[0].side <= side7;
    end
  end

  for (genvar i = 0; i < sgp_pkg::SQRT_STAGES; i++) begin : g_sqrt
    localparam int K = sgp_pkg::ROOT_BITS - 1 - i;
    logic [sgp_pkg::REM_BITS+1:0] rin, trial;
    sgp_pkg::sqrt_t               nxt;

    always_comb begin
      rin   = {sq[i].rem, sq[i].rad[2*K+1 -: 2]};
      trial = {1'b0, sq[i].root, 2'b01};
      nxt   = sq[i];
      if (rin >= trial) begin
        nxt.rem  = sgp_pkg::REM_BITS'(rin - trial);
        nxt.root = {sq[i].root[sgp_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
        nxt.rem  = sgp_pkg::REM_BITS'(rin);
        nxt.root = {sq[i].root[sgp_pkg::ROOT_BITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq[i+1] <= nxt;
      end
    end
  end

  // degree search against the tangent list, one bit per stage
  sgp_pkg::atan_t pan_at  [0:sgp_pkg::SEARCH_STAGES];
  sgp_pkg::atan_t tilt_at [0:sgp_pkg::SEARCH_STAGES];
  sgp_pkg::side_t side_end;

  assign side_end = sq[sgp_pkg::SQRT_STAGES].side;

  always_ff @(posedge clk) begin
    if (adv) begin
      pan_at[0]  <= sgp_pkg::atan_prep(sgp_pkg::ROOT_BITS'(side_end.pan_p),
                                       sgp_pkg::ROOT_BITS'(side_end.pan_q),
                                       side_end.pan_neg);
      tilt_at[0] <= sgp_pkg::atan_prep(sgp_pkg::ROOT_BITS'(side_end.tilt_y),
                                       sq[sgp_pkg::SQRT_STAGES].root,
                                       side_end.tilt_neg);
    end
  end

  for (genvar j = 0; j < sgp_pkg::SEARCH_STAGES; j++) begin : g_search
    localparam logic [sgp_pkg::DEG_BITS-1:0] MASK =
      sgp_pkg::DEG_BITS'(1) << (sgp_pkg::SEARCH_STAGES - 1 - j);

    always_ff @(posedge clk) begin
      if (adv) begin
        pan_at[j+1]  <= sgp_pkg::atan_step(pan_at[j], MASK);
        tilt_at[j+1] <= sgp_pkg::atan_step(tilt_at[j], MASK);
      end
    end
  end

  // angles and pulse map
  logic [7:0]         pan_a1, tilt_a1, pan_a2, tilt_a2, pan_a3, tilt_a3;
  logic signed [23:0] pan_t, tilt_t;
  logic [38:0]        pan_prod, tilt_prod;
  logic signed [12:0] pan_diff, tilt_diff;
  logic [18:0]        pan_u, tilt_u;

  assign pan_diff  = $signed({1'b0, pan_max}) - $signed({1'b0, pan_min});
  assign tilt_diff = $signed({1'b0, tilt_max}) - $signed({1'b0, tilt_min});
  assign pan_u     = 19'((pan_t >>> 3) + $signed(24'(sgp_pkg::DIV_OFFSET)));
  assign tilt_u    = 19'((tilt_t >>> 3) + $signed(24'(sgp_pkg::DIV_OFFSET)));

  always_ff @(posedge clk) begin
    if (adv) begin
      pan_a1     <= sgp_pkg::atan_angle(pan_at[sgp_pkg::SEARCH_STAGES]);
      tilt_a1    <= sgp_pkg::atan_angle(tilt_at[sgp_pkg::SEARCH_STAGES]);

      pan_t      <= 24'sd180 + 24'($signed({1'b0, pan_a1, 1'b0})) * 24'(pan_diff);
      tilt_t     <= 24'sd180 + 24'($signed({1'b0, tilt_a1, 1'b0})) * 24'(tilt_diff);
      pan_a2     <= pan_a1;
      tilt_a2    <= tilt_a1;

      pan_prod   <= 39'(pan_u) * 39'(sgp_pkg::DIV_MUL);
      tilt_prod  <= 39'(tilt_u) * 39'(sgp_pkg::DIV_MUL);
      pan_a3     <= pan_a2;
      tilt_a3    <= tilt_a2;

      pan_angle  <= pan_a3;
      tilt_angle <= tilt_a3;
      pan_pulse  <= pan_min + pan_prod[sgp_pkg::DIV_SHIFT +: 12];
      tilt_pulse <= tilt_min + tilt_prod[sgp_pkg::DIV_SHIFT +: 12];
    end
  end

  `SGP_ASSERT_NOW(a_angle_range, cmd_valid, pan_angle <= 8'd180 && tilt_angle <= 8'd180)
  `SGP_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld))
  `SGP_ASSERT_NEXT(a_transfer_enters, sample_valid && sample_ready, vld[0])
  `SGP_ASSERT_AFTER_RESET(a_reset_empty, !cmd_valid)

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int LATENCY   = 48;
  localparam int IDLE_PCT  = 28;
  localparam int WDOG_MAX  = 4000;
  localparam int HOLD_LEN  = 400;
  localparam logic [2:0] REG_UNUSED_A = 3'd6;
  localparam logic [2:0] REG_UNUSED_B = 3'd7;

  typedef struct packed {
    logic signed [15:0] sr;
    logic signed [15:0] cr;
    logic signed [15:0] sp;
    logic signed [15:0] cp;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } sample_t;

  typedef struct packed {
    logic [7:0]  pan;
    logic [7:0]  tilt;
    logic [11:0] pan_us;
    logic [11:0] tilt_us;
  } cmd_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [11:0] cfg_data;
  logic sample_valid;
  logic sample_ready;
  logic signed [15:0] roll_sin, roll_cos, pitch_sin, pitch_cos, vel_x, vel_y;
  logic cmd_valid;
  logic cmd_ready;
  logic [7:0] pan_angle, tilt_angle;
  logic [11:0] pan_pulse, tilt_pulse;

  sensor_gimbal_pointing_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_ready(sample_ready),
    .roll_sin(roll_sin), .roll_cos(roll_cos), .pitch_sin(pitch_sin),
    .pitch_cos(pitch_cos), .vel_x(vel_x), .vel_y(vel_y),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .pan_angle(pan_angle), .tilt_angle(tilt_angle),
    .pan_pulse(pan_pulse), .tilt_pulse(tilt_pulse)
  );

  logic [7:0]  dt_q8;
  logic [9:0]  height;
  logic [11:0] pan_lo, pan_hi, tilt_lo, tilt_hi;

  cmd_t pending_cmds[$];
  int   errors = 0;
  int   hold_left;
  int   hold_reqs;
  int   holds_seen;
  bit   steady_rx;
  bit   steady_tx;
  int   stall_cycles;

  longint unsigned tan_deg[46] = '{
    64'd0, 64'd174550649, 64'd349207695, 64'd524077793, 64'd699268119,
    64'd874886635, 64'd1051042353, 64'd1227845609, 64'd1405408347, 64'd1583844403,
    64'd1763269807, 64'd1943803091, 64'd2125565617, 64'd2308681911, 64'd2493280028,
    64'd2679491924, 64'd2867453858, 64'd3057306815, 64'd3249196962, 64'd3443276133,
    64'd3639702343, 64'd3838640350, 64'd4040262258, 64'd4244748162, 64'd4452286853,
    64'd4663076582, 64'd4877325886, 64'd5095254495, 64'd5317094317, 64'd5543090515,
    64'd5773502692, 64'd6008606190, 64'd6248693519, 64'd6494075932, 64'd6745085168,
    64'd7002075382, 64'd7265425280, 64'd7535540501, 64'd7812856265, 64'd8097840332,
    64'd8390996312, 64'd8692867378, 64'd9004040443, 64'd9325150861, 64'd9656887748,
    64'd10000000000
  };

  function automatic longint unsigned abs64(input longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic int shift_to_fit(input longint unsigned m);
    int s;
    s = 0;
    while ((m >> s) >= 64'd268435456) s++;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int whole_deg(input longint unsigned p, input longint unsigned q);
    int n;
    n = 0;
    if (p == 0) return 0;
    if (p <= q) begin
      for (int d = 1; d <= 45; d++)
        if (tan_deg[d] * q <= p * 64'd10000000000) n = d;
      return n;
    end
    for (int d = 0; d <= 44; d++)
      if (tan_deg[d] * p < q * 64'd10000000000) n++;
    n = 90 - n;
    return n > 89 ? 89 : n;
  endfunction

  function automatic logic [11:0] servo_us(input int a, input int lo, input int hi);
    int t, q;
    t = 2 * a * (hi - lo) + 180;
    q = t >= 0 ? t / 360 : -((-t + 359) / 360);
    return 12'(lo + q);
  endfunction

  function automatic cmd_t aim_gimbal(input sample_t s);
    longint sr, cr, sp, cp, p, q, h, sx, sy, sz;
    longint unsigned ax, ay, az, m, r;
    int sh, pan, tilt;
    cmd_t c;
    sr = s.sr; cr = s.cr; sp = s.sp; cp = s.cp;
    p = longint'(s.vx) * longint'(dt_q8);
    q = longint'(s.vy) * longint'(dt_q8);
    h = longint'(height) * 256;
    sx = (cp * p - sp * h) * 16384;
    sy = sr * sp * p + cr * q * 16384 + sr * cp * h;
    sz = cr * sp * p - sr * q * 16384 + cr * cp * h;
    if (sz == 0) sz = 1;
    ax = abs64(sx); ay = abs64(sy); az = abs64(sz);
    m = ax > az ? ax : az;
    sh = shift_to_fit(m);
    pan = whole_deg(ax >> sh, az >> sh);
    if ((sx < 0) != (sz < 0)) pan = -pan;
    if (ay > m) m = ay;
    sh = shift_to_fit(m);
    r = int_sqrt((ax >> sh) * (ax >> sh) + (az >> sh) * (az >> sh));
    tilt = whole_deg(ay >> sh, r);
    if ((sy < 0) == (sz < 0)) tilt = -tilt;
    pan = pan + 90;
    tilt = tilt + 90;
    if (pan < 0) pan = 0;
    if (pan > 180) pan = 180;
    if (tilt < 0) tilt = 0;
    if (tilt > 180) tilt = 180;
    c.pan = 8'(pan);
    c.tilt = 8'(tilt);
    c.pan_us = servo_us(pan, pan_lo, pan_hi);
    c.tilt_us = servo_us(tilt, tilt_lo, tilt_hi);
    return c;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("%0t %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cmd_t e;
    if (!rst && cmd_valid && cmd_ready) begin
      if (pending_cmds.size() == 0) begin
        report("unexpected command", pan_angle, -1);
      end else begin
        e = pending_cmds.pop_front();
        if (pan_angle !== e.pan) report("pan_angle", pan_angle, e.pan);
        if (tilt_angle !== e.tilt) report("tilt_angle", tilt_angle, e.tilt);
        if (pan_pulse !== e.pan_us) report("pan_pulse", pan_pulse, e.pan_us);
        if (tilt_pulse !== e.tilt_us) report("tilt_pulse", tilt_pulse, e.tilt_us);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cmd_ready <= 1'b0;
      hold_left <= 0;
      holds_seen <= 0;
    end else if (holds_seen != hold_reqs) begin
      cmd_ready <= 1'b0;
      hold_left <= HOLD_LEN;
      holds_seen <= hold_reqs;
    end else if (hold_left > 0) begin
      cmd_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (steady_rx) begin
      cmd_ready <= 1'b1;
    end else begin
      cmd_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (cmd_valid && cmd_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WDOG_MAX) begin
      $display("sensor_gimbal_pointing_unit: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_sample(input sample_t s);
    if (!steady_tx) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        sample_valid <= 1'b0;
        @(posedge clk);
      end
    end
    sample_valid <= 1'b1;
    {roll_sin, roll_cos, pitch_sin, pitch_cos, vel_x, vel_y} <= s;
    do @(posedge clk); while (!sample_ready);
    pending_cmds.push_back(aim_gimbal(s));
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sgp_pkg::REG_STEP_TIME:  dt_q8 = val[7:0];
      sgp_pkg::REG_REF_HEIGHT: height = val[9:0];
      sgp_pkg::REG_PAN_MIN:    pan_lo = val;
      sgp_pkg::REG_PAN_MAX:    pan_hi = val;
      sgp_pkg::REG_TILT_MIN:   tilt_lo = val;
      sgp_pkg::REG_TILT_MAX:   tilt_hi = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [11:0] st, input logic [11:0] ht, input logic [11:0] p0,
                           input logic [11:0] p1, input logic [11:0] t0, input logic [11:0] t1);
    write_reg(sgp_pkg::REG_STEP_TIME, st);
    write_reg(sgp_pkg::REG_REF_HEIGHT, ht);
    write_reg(sgp_pkg::REG_PAN_MIN, p0);
    write_reg(sgp_pkg::REG_PAN_MAX, p1);
    write_reg(sgp_pkg::REG_TILT_MIN, t0);
    write_reg(sgp_pkg::REG_TILT_MAX, t1);
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    int k;
    k = $urandom_range(99);
    if (k < 70) begin
      s.sr = 16'($signed($urandom_range(32768)) - 16384);
      s.cr = 16'($signed($urandom_range(32768)) - 16384);
      s.sp = 16'($signed($urandom_range(32768)) - 16384);
      s.cp = 16'($signed($urandom_range(32768)) - 16384);
      if (k < 35) begin
        s.vx = 16'($signed($urandom_range(2000)) - 1000);
        s.vy = 16'($signed($urandom_range(2000)) - 1000);
      end else begin
        s.vx = 16'($urandom);
        s.vy = 16'($urandom);
      end
    end else begin
      s = {$urandom, $urandom, $urandom};
      if (k < 80) s.sr = 0;
      if (k >= 90) s.cp = 0;
    end
    return s;
  endfunction

  task automatic test_directed();
    sample_t s;
    steady_tx = 1;
    send_sample('0);
    send_sample({16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    send_sample({16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd500, 16'sd0});
    send_sample({16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd32767});
    send_sample({16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd32768});
    send_sample({16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd100, 16'sd100});
    send_sample({-16'sd16384, 16'sd0, -16'sd16384, 16'sd0, -16'sd100, -16'sd100});
    send_sample({16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585, 16'sd0, 16'sd0});
    send_sample({-16'sd11585, 16'sd11585, 16'sd11585, -16'sd11585, 16'sd300, -16'sd300});
    send_sample({16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
    send_sample({-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
    send_sample({-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768});
    send_sample({16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0});
    send_sample({16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    send_sample({16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    send_sample({16'sd0, 16'sd16384, -16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    steady_tx = 0;
    for (int i = 0; i < 6; i++) begin
      s = {$urandom, $urandom, $urandom};
      send_sample(s);
    end
    drain();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_sample(random_sample());
    drain();
  endtask

  task automatic test_config_extremes();
    write_all(12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0);
    write_reg(REG_UNUSED_A, 12'hFFF);
    write_reg(REG_UNUSED_B, 12'h000);
    test_random(60);
    write_all(12'hFFF, 12'hFFF, 12'd4095, 12'd0, 12'd0, 12'd4095);
    test_random(80);
    write_all(12'd255, 12'd1, 12'd1000, 12'd1000, 12'd2000, 12'd1999);
    test_random(60);
    write_all(12'd1, 12'd1023, 12'd715, 12'd2345, 12'd590, 12'd2360);
    test_random(60);
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    steady_tx = 1;
    for (int i = 0; i < 80; i++) send_sample(random_sample());
    steady_tx = 0;
    drain();
  endtask

  task automatic test_steady();
    steady_rx = 1;
    steady_tx = 1;
    test_random(80);
    steady_rx = 0;
    steady_tx = 0;
    write_all(12'($urandom_range(255)), 12'($urandom_range(1023)), 12'($urandom),
              12'($urandom), 12'($urandom), 12'($urandom));
    test_random(120);
  endtask

  initial begin
    hold_reqs = 0;
    steady_rx = 0;
    steady_tx = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_valid = 1'b0;
    {roll_sin, roll_cos, pitch_sin, pitch_cos, vel_x, vel_y} = '0;
    dt_q8 = sgp_pkg::RST_STEP_TIME;
    height = sgp_pkg::RST_REF_HEIGHT;
    pan_lo = sgp_pkg::RST_PAN_MIN;
    pan_hi = sgp_pkg::RST_PAN_MAX;
    tilt_lo = sgp_pkg::RST_TILT_MIN;
    tilt_hi = sgp_pkg::RST_TILT_MAX;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100);
    test_backpressure();
    test_config_extremes();
    test_steady();
    if (errors == 0) begin
      $display("sensor_gimbal_pointing_unit: match");
    end else begin
      $display("sensor_gimbal_pointing_unit: mismatch");
    end
    $finish;
  end

endmodule
